// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL. All checks sample on clk and
// are disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define TCC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TCC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/tcc_pkg.sv =====
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types and constants of the tilt-compensated compass heading block.
// ----------------------------------------------------------------------------
package tcc_pkg;

  localparam int TCC_SENS_W      = 16;
  localparam int TCC_REF_W       = 8;
  localparam int TCC_HEAD_W      = 15;
  localparam int TCC_IDX_W       = 3;
  localparam int TCC_ANGLE_FRAC  = 6;
  localparam int TCC_SQRT_STEPS  = 20;
  localparam int TCC_NORM_STEPS  = 6;
  localparam int TCC_CORDIC_STEPS = 20;

  localparam int TCC_PE_W   = 44;
  localparam int TCC_PN_W   = 61;
  localparam int TCC_SQ_W   = 41;
  localparam int TCC_SA_W   = 20;
  localparam int TCC_U_W    = 63;
  localparam int TCC_CX_W   = 34;
  localparam int TCC_Z_W    = 25;

  typedef enum logic [TCC_IDX_W-1:0] {
    TCC_REG_OFFSET_X = 3'd0,
    TCC_REG_OFFSET_Y = 3'd1,
    TCC_REG_OFFSET_Z = 3'd2,
    TCC_REG_REF_X    = 3'd3,
    TCC_REG_REF_Y    = 3'd4,
    TCC_REG_REF_Z    = 3'd5
  } tcc_reg_t;

  localparam logic signed [TCC_SENS_W-1:0] TCC_RST_OFFSET_X = 16'sd346;
  localparam logic signed [TCC_SENS_W-1:0] TCC_RST_OFFSET_Y = -16'sd1133;
  localparam logic signed [TCC_SENS_W-1:0] TCC_RST_OFFSET_Z = -16'sd525;
  localparam logic signed [TCC_REF_W-1:0]  TCC_RST_REF_X    = 8'sd1;
  localparam logic signed [TCC_REF_W-1:0]  TCC_RST_REF_Y    = 8'sd0;
  localparam logic signed [TCC_REF_W-1:0]  TCC_RST_REF_Z    = 8'sd0;

  // Arctangent of 2^-i in 2^-16 degree units.
  localparam int TCC_ATAN_TAB [TCC_CORDIC_STEPS] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
  };

  typedef struct packed {
    logic signed [TCC_SENS_W-1:0] mag_x;
    logic signed [TCC_SENS_W-1:0] mag_y;
    logic signed [TCC_SENS_W-1:0] mag_z;
    logic signed [TCC_SENS_W-1:0] accel_x;
    logic signed [TCC_SENS_W-1:0] accel_y;
    logic signed [TCC_SENS_W-1:0] accel_z;
  } tcc_in_t;

  typedef struct packed {
    logic signed [TCC_SENS_W-1:0] offset_x;
    logic signed [TCC_SENS_W-1:0] offset_y;
    logic signed [TCC_SENS_W-1:0] offset_z;
    logic signed [TCC_REF_W-1:0]  ref_x;
    logic signed [TCC_REF_W-1:0]  ref_y;
    logic signed [TCC_REF_W-1:0]  ref_z;
  } tcc_cfg_t;

  // Projections that ride along the square-root chain.
  typedef struct packed {
    logic                       deg;
    logic signed [TCC_PE_W-1:0] pe;
    logic signed [TCC_PN_W-1:0] pn;
  } tcc_side_t;

  typedef struct packed {
    logic [TCC_SQ_W-1:0] rem;
    logic [TCC_SQ_W-1:0] root;
  } tcc_sqrt_t;

  typedef struct packed {
    logic                deg;
    logic                zero;
    logic                xneg;
    logic                yneg;
    logic [TCC_U_W-1:0]  ux;
    logic [TCC_U_W-1:0]  uy;
    logic [TCC_U_W-1:0]  mx;
  } tcc_norm_t;

  typedef struct packed {
    logic                       deg;
    logic                       zero;
    logic                       xneg;
    logic                       yneg;
    logic signed [TCC_CX_W-1:0] x;
    logic signed [TCC_CX_W-1:0] y;
    logic signed [TCC_Z_W-1:0]  z;
  } tcc_cordic_t;

endpackage

// ===== src/tcc_if.sv =====
// ----------------------------------------------------------------------------
// tcc_if
// Valid/ready channel interfaces of the compass heading block.
// ----------------------------------------------------------------------------
interface tcc_in_if import tcc_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [TCC_SENS_W-1:0] mag_x;
  logic signed [TCC_SENS_W-1:0] mag_y;
  logic signed [TCC_SENS_W-1:0] mag_z;
  logic signed [TCC_SENS_W-1:0] accel_x;
  logic signed [TCC_SENS_W-1:0] accel_y;
  logic signed [TCC_SENS_W-1:0] accel_z;
  modport source (output valid, mag_x, mag_y, mag_z, accel_x, accel_y, accel_z,
                  input ready);
  modport sink (input valid, mag_x, mag_y, mag_z, accel_x, accel_y, accel_z,
                output ready);
endinterface

interface tcc_out_if import tcc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [TCC_HEAD_W-1:0] heading;
  logic                  degenerate;
  modport source (output valid, heading, degenerate, input ready);
  modport sink (input valid, heading, degenerate, output ready);
endinterface

interface tcc_cfg_if import tcc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [TCC_IDX_W-1:0]  index;
  logic [TCC_SENS_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/tcc_front.sv =====
// ----------------------------------------------------------------------------
// tcc_front
// Offset removal, East and North cross products and reference projections.
// ----------------------------------------------------------------------------
module tcc_front import tcc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      vld_i,
  input  tcc_in_t   d_i,
  input  tcc_cfg_t  cfg,
  output logic      vld_o,
  output tcc_sqrt_t sq_o,
  output tcc_side_t sd_o
);

  logic [6:0] vld_r;

  logic signed [16:0] mx_r, my_r, mz_r;
  logic signed [15:0] ax_r, ay_r, az_r, ax2_r, ay2_r, az2_r, ax3_r, ay3_r, az3_r;
  logic signed [32:0] p_myaz_r, p_mzay_r, p_mzax_r, p_mxaz_r, p_mxay_r, p_myax_r;
  logic signed [31:0] qx_r, qy_r, qz_r;
  logic signed [33:0] ex_r, ey_r, ez_r;
  logic [31:0]        ss3_r, ss4_r, ss5_r, ss6_r, ss7_r;
  logic signed [49:0] p_ayez_r, p_azey_r, p_azex_r, p_axez_r, p_axey_r, p_ayex_r;
  logic signed [41:0] q_ex_r, q_ey_r, q_ez_r;
  logic               deg4_r, deg5_r, deg6_r, deg7_r;
  logic signed [50:0] nx_r, ny_r, nz_r;
  logic signed [43:0] pe5_r, pe6_r, pe7_r;
  logic signed [58:0] q_nx_r, q_ny_r, q_nz_r;
  logic signed [60:0] pn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[5:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx_r <= 17'(d_i.mag_x) - 17'(cfg.offset_x);
      my_r <= 17'(d_i.mag_y) - 17'(cfg.offset_y);
      mz_r <= 17'(d_i.mag_z) - 17'(cfg.offset_z);
      ax_r <= d_i.accel_x;
      ay_r <= d_i.accel_y;
      az_r <= d_i.accel_z;

      p_myaz_r <= my_r * az_r;
      p_mzay_r <= mz_r * ay_r;
      p_mzax_r <= mz_r * ax_r;
      p_mxaz_r <= mx_r * az_r;
      p_mxay_r <= mx_r * ay_r;
      p_myax_r <= my_r * ax_r;
      qx_r     <= ax_r * ax_r;
      qy_r     <= ay_r * ay_r;
      qz_r     <= az_r * az_r;
      ax2_r    <= ax_r;
      ay2_r    <= ay_r;
      az2_r    <= az_r;

      ex_r  <= 34'(p_myaz_r) - 34'(p_mzay_r);
      ey_r  <= 34'(p_mzax_r) - 34'(p_mxaz_r);
      ez_r  <= 34'(p_mxay_r) - 34'(p_myax_r);
      ss3_r <= $unsigned(qx_r) + $unsigned(qy_r) + $unsigned(qz_r);
      ax3_r <= ax2_r;
      ay3_r <= ay2_r;
      az3_r <= az2_r;

      p_ayez_r <= ay3_r * ez_r;
      p_azey_r <= az3_r * ey_r;
      p_azex_r <= az3_r * ex_r;
      p_axez_r <= ax3_r * ez_r;
      p_axey_r <= ax3_r * ey_r;
      p_ayex_r <= ay3_r * ex_r;
      q_ex_r   <= ex_r * cfg.ref_x;
      q_ey_r   <= ey_r * cfg.ref_y;
      q_ez_r   <= ez_r * cfg.ref_z;
      deg4_r   <= (ex_r == '0) && (ey_r == '0) && (ez_r == '0);
      ss4_r    <= ss3_r;

      nx_r   <= 51'(p_ayez_r) - 51'(p_azey_r);
      ny_r   <= 51'(p_azex_r) - 51'(p_axez_r);
      nz_r   <= 51'(p_axey_r) - 51'(p_ayex_r);
      pe5_r  <= 44'(q_ex_r) + 44'(q_ey_r) + 44'(q_ez_r);
      deg5_r <= deg4_r;
      ss5_r  <= ss4_r;

      q_nx_r <= nx_r * cfg.ref_x;
      q_ny_r <= ny_r * cfg.ref_y;
      q_nz_r <= nz_r * cfg.ref_z;
      pe6_r  <= pe5_r;
      deg6_r <= deg5_r;
      ss6_r  <= ss5_r;

      pn_r   <= 61'(q_nx_r) + 61'(q_ny_r) + 61'(q_nz_r);
      pe7_r  <= pe6_r;
      deg7_r <= deg6_r;
      ss7_r  <= ss6_r;
    end
  end

  assign vld_o   = vld_r[6];
  // The root is taken of 256 * |accel|^2, which gives four fraction bits.
  assign sq_o.rem  = {1'b0, ss7_r, 8'h00};
  assign sq_o.root = '0;
  assign sd_o.deg  = deg7_r;
  assign sd_o.pe   = pe7_r;
  assign sd_o.pn   = pn_r;

endmodule

// ===== src/tcc_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// tcc_sqrt_cell
// One digit of the integer square root of |accel|^2.
// ----------------------------------------------------------------------------
module tcc_sqrt_cell import tcc_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      vld_i,
  input  tcc_sqrt_t sq_i,
  input  tcc_side_t sd_i,
  output logic      vld_o,
  output tcc_sqrt_t sq_o,
  output tcc_side_t sd_o
);

  localparam logic [TCC_SQ_W-1:0] BIT = TCC_SQ_W'(1) << (2 * IDX);

  logic                vld_r;
  tcc_sqrt_t           sq_r, sq_nxt;
  tcc_side_t           sd_r;
  logic [TCC_SQ_W-1:0] trial;

  always_comb begin
    trial = sq_i.root + BIT;
    if (sq_i.rem >= trial) begin
      sq_nxt.rem  = sq_i.rem - trial;
      sq_nxt.root = (sq_i.root >> 1) + BIT;
    end else begin
      sq_nxt.rem  = sq_i.rem;
      sq_nxt.root = sq_i.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r <= sq_nxt;
      sd_r <= sd_i;
    end
  end

  assign vld_o = vld_r;
  assign sq_o  = sq_r;
  assign sd_o  = sd_r;

endmodule

// ===== src/tcc_proj.sv =====
// ----------------------------------------------------------------------------
// tcc_proj
// Scales the East projection by |accel| and takes signs and magnitudes.
// ----------------------------------------------------------------------------
module tcc_proj import tcc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      vld_i,
  input  tcc_sqrt_t sq_i,
  input  tcc_side_t sd_i,
  output logic      vld_o,
  output tcc_norm_t d_o
);

  logic [1:0]         vld_r;
  logic signed [63:0] x_r, y_r;
  logic               deg_r;
  tcc_norm_t          d_r;
  logic [63:0]        ax, ay;
  logic signed [20:0] sa;
  logic signed [64:0] y_wide;

  assign sa     = $signed({1'b0, sq_i.root[TCC_SA_W-1:0]});
  assign y_wide = {sd_i.pn, 4'h0};
  assign ax     = x_r[63] ? 64'(-x_r) : 64'(x_r);
  assign ay     = y_r[63] ? 64'(-y_r) : 64'(y_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r   <= 64'(sd_i.pe * sa);
      y_r   <= y_wide[63:0];
      deg_r <= sd_i.deg;

      d_r.deg  <= deg_r;
      d_r.zero <= (x_r == '0) && (y_r == '0);
      d_r.xneg <= x_r[63];
      d_r.yneg <= y_r[63];
      d_r.ux   <= ax[TCC_U_W-1:0];
      d_r.uy   <= ay[TCC_U_W-1:0];
      d_r.mx   <= (ax > ay) ? ax[TCC_U_W-1:0] : ay[TCC_U_W-1:0];
    end
  end

  assign vld_o = vld_r[1];
  assign d_o   = d_r;

endmodule

// ===== src/tcc_norm_cell.sv =====
// ----------------------------------------------------------------------------
// tcc_norm_cell
// One step of the left shift that brings the larger magnitude to the top.
// ----------------------------------------------------------------------------
module tcc_norm_cell import tcc_pkg::*; #(
  parameter int SH = 1
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      vld_i,
  input  tcc_norm_t d_i,
  output logic      vld_o,
  output tcc_norm_t d_o
);

  logic      vld_r;
  tcc_norm_t d_r, d_nxt;

  always_comb begin
    d_nxt = d_i;
    if (d_i.mx[TCC_U_W-1 -: SH] == '0) begin
      d_nxt.ux = d_i.ux << SH;
      d_nxt.uy = d_i.uy << SH;
      d_nxt.mx = d_i.mx << SH;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign vld_o = vld_r;
  assign d_o   = d_r;

endmodule

// ===== src/tcc_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// tcc_cordic_cell
// One vectoring CORDIC micro-rotation with its arctangent step.
// ----------------------------------------------------------------------------
module tcc_cordic_cell import tcc_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        vld_i,
  input  tcc_cordic_t d_i,
  output logic        vld_o,
  output tcc_cordic_t d_o
);

  localparam logic signed [TCC_Z_W-1:0] ANG = TCC_Z_W'(TCC_ATAN_TAB[IDX]);

  logic                       vld_r;
  tcc_cordic_t                d_r, d_nxt;
  logic signed [TCC_CX_W-1:0] x, y, dx, dy;
  logic signed [TCC_Z_W-1:0]  z;

  assign x  = d_i.x;
  assign y  = d_i.y;
  assign z  = d_i.z;
  assign dx = y >>> IDX;
  assign dy = x >>> IDX;

  always_comb begin
    d_nxt = d_i;
    if (!y[TCC_CX_W-1]) begin
      d_nxt.x = x + dx;
      d_nxt.y = y - dy;
      d_nxt.z = z + ANG;
    end else begin
      d_nxt.x = x - dx;
      d_nxt.y = y + dy;
      d_nxt.z = z - ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign vld_o = vld_r;
  assign d_o   = d_r;

endmodule

// ===== src/tilt_compensated_compass_heading_top.sv =====
// ----------------------------------------------------------------------------
// tilt_compensated_compass_heading_top
// Tilt-compensated compass heading: pipelined cross products, square-root,
// normalize and CORDIC cell chains, with an output skid register.
//
//   channel  dir  payload                                   handshake
//   in_ch    in   mag_x/y/z, accel_x/y/z (16b signed)       valid/ready
//   out_ch   out  heading (15b), degenerate (1b)            valid/ready
//   cfg_ch   in   index (3b), data (16b)                    valid/ready
//
// One transaction is taken per cycle while the pipe is not held; a result
// passes in order through the 7 front stages, 20 square-root cells,
// 2 projection stages, 6 normalize cells, 20 CORDIC cells and 2 output
// stages. The whole pipe holds while the skid register is full, which
// happens only when a result arrives at a stalled output. Reset clears
// the valid bits and loads the register defaults. cfg_ch is always ready.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tilt_compensated_compass_heading_top import tcc_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = TCC_ANGLE_FRAC
) (
  input  logic clk,
  input  logic rst_n,
  tcc_in_if.sink    in_ch,
  tcc_out_if.source out_ch,
  tcc_cfg_if.sink   cfg_ch
);

  localparam int SHR = 16 - ANGLE_FRAC_BITS;
  localparam logic signed [27:0] RND  = 28'sd1 <<< (15 - ANGLE_FRAC_BITS);
  localparam logic signed [27:0] FULL = 28'sd360 <<< ANGLE_FRAC_BITS;
  localparam logic signed [27:0] HALF_TURN = 28'sd180 <<< 16;
  localparam logic signed [27:0] FULL_TURN = 28'sd360 <<< 16;

  tcc_cfg_t cfg_r;
  logic     en;
  tcc_in_t  in_d;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.offset_x <= TCC_RST_OFFSET_X;
      cfg_r.offset_y <= TCC_RST_OFFSET_Y;
      cfg_r.offset_z <= TCC_RST_OFFSET_Z;
      cfg_r.ref_x    <= TCC_RST_REF_X;
      cfg_r.ref_y    <= TCC_RST_REF_Y;
      cfg_r.ref_z    <= TCC_RST_REF_Z;
    end else if (cfg_ch.valid) begin
      case (tcc_reg_t'(cfg_ch.index))
        TCC_REG_OFFSET_X: cfg_r.offset_x <= cfg_ch.data;
        TCC_REG_OFFSET_Y: cfg_r.offset_y <= cfg_ch.data;
        TCC_REG_OFFSET_Z: cfg_r.offset_z <= cfg_ch.data;
        TCC_REG_REF_X:    cfg_r.ref_x    <= cfg_ch.data[TCC_REF_W-1:0];
        TCC_REG_REF_Y:    cfg_r.ref_y    <= cfg_ch.data[TCC_REF_W-1:0];
        TCC_REG_REF_Z:    cfg_r.ref_z    <= cfg_ch.data[TCC_REF_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = en;

  assign in_d.mag_x   = in_ch.mag_x;
  assign in_d.mag_y   = in_ch.mag_y;
  assign in_d.mag_z   = in_ch.mag_z;
  assign in_d.accel_x = in_ch.accel_x;
  assign in_d.accel_y = in_ch.accel_y;
  assign in_d.accel_z = in_ch.accel_z;

  // Front end.
  logic      sq_vld [TCC_SQRT_STEPS+1];
  tcc_sqrt_t sq_c   [TCC_SQRT_STEPS+1];
  tcc_side_t sd_c   [TCC_SQRT_STEPS+1];

  tcc_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (in_ch.valid && en),
    .d_i   (in_d),
    .cfg   (cfg_r),
    .vld_o (sq_vld[0]),
    .sq_o  (sq_c[0]),
    .sd_o  (sd_c[0])
  );

  // Square-root chain, most significant digit first.
  for (genvar i = 0; i < TCC_SQRT_STEPS; i++) begin : g_sqrt
    tcc_sqrt_cell #(.IDX(TCC_SQRT_STEPS - 1 - i)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vld_i (sq_vld[i]),
      .sq_i  (sq_c[i]),
      .sd_i  (sd_c[i]),
      .vld_o (sq_vld[i+1]),
      .sq_o  (sq_c[i+1]),
      .sd_o  (sd_c[i+1])
    );
  end

  logic      nm_vld [TCC_NORM_STEPS+1];
  tcc_norm_t nm_c   [TCC_NORM_STEPS+1];

  tcc_proj u_proj (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (sq_vld[TCC_SQRT_STEPS]),
    .sq_i  (sq_c[TCC_SQRT_STEPS]),
    .sd_i  (sd_c[TCC_SQRT_STEPS]),
    .vld_o (nm_vld[0]),
    .d_o   (nm_c[0])
  );

  for (genvar i = 0; i < TCC_NORM_STEPS; i++) begin : g_norm
    tcc_norm_cell #(.SH(32 >> i)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vld_i (nm_vld[i]),
      .d_i   (nm_c[i]),
      .vld_o (nm_vld[i+1]),
      .d_o   (nm_c[i+1])
    );
  end

  logic        cr_vld [TCC_CORDIC_STEPS+1];
  tcc_cordic_t cr_c   [TCC_CORDIC_STEPS+1];
  tcc_norm_t   nm_end;

  // The top 30 bits of the normalized magnitudes start the rotation:
  // x takes the North magnitude, y the East magnitude.
  assign nm_end         = nm_c[TCC_NORM_STEPS];
  assign cr_vld[0]      = nm_vld[TCC_NORM_STEPS];
  assign cr_c[0].deg    = nm_end.deg;
  assign cr_c[0].zero   = nm_end.zero;
  assign cr_c[0].xneg   = nm_end.xneg;
  assign cr_c[0].yneg   = nm_end.yneg;
  assign cr_c[0].x      = $signed({4'h0, nm_end.uy[TCC_U_W-1 -: 30]});
  assign cr_c[0].y      = $signed({4'h0, nm_end.ux[TCC_U_W-1 -: 30]});
  assign cr_c[0].z      = '0;

  for (genvar i = 0; i < TCC_CORDIC_STEPS; i++) begin : g_cordic
    tcc_cordic_cell #(.IDX(i)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vld_i (cr_vld[i]),
      .d_i   (cr_c[i]),
      .vld_o (cr_vld[i+1]),
      .d_o   (cr_c[i+1])
    );
  end

  // Quadrant, rounding and wrap.
  tcc_cordic_t      cr_end;
  logic signed [27:0] z_ext, ang, ang_r, rnd, wrapped;
  logic [TCC_HEAD_W-1:0] fin_head_r;
  logic                  fin_deg_r, fin_vld_r;

  assign cr_end = cr_c[TCC_CORDIC_STEPS];
  assign z_ext  = 28'(cr_end.z);

  always_comb begin
    if (!cr_end.yneg && !cr_end.xneg) begin
      ang = z_ext;
    end else if (cr_end.yneg && !cr_end.xneg) begin
      ang = HALF_TURN - z_ext;
    end else if (cr_end.yneg) begin
      ang = HALF_TURN + z_ext;
    end else begin
      ang = FULL_TURN - z_ext;
    end
    ang_r = ang + RND;
    rnd   = ang_r >>> SHR;
    if (rnd < 0) begin
      wrapped = rnd + FULL;
    end else if (rnd >= FULL) begin
      wrapped = rnd - FULL;
    end else begin
      wrapped = rnd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_vld_r <= 1'b0;
    end else if (en) begin
      fin_vld_r <= cr_vld[TCC_CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_deg_r  <= cr_end.deg;
      fin_head_r <= (cr_end.deg || cr_end.zero) ? '0 : wrapped[TCC_HEAD_W-1:0];
    end
  end

  // Output register with a one-entry skid stage.
  logic                  out_vld_r, skid_vld_r;
  logic [TCC_HEAD_W-1:0] out_head_r, skid_head_r;
  logic                  out_deg_r, skid_deg_r;
  logic                  fin_take;

  assign en       = !skid_vld_r;
  assign fin_take = fin_vld_r && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_vld_r && !out_ch.ready) begin
      if (fin_take) begin
        skid_vld_r <= 1'b1;
      end
    end else if (skid_vld_r) begin
      out_vld_r  <= 1'b1;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r <= fin_take;
    end
  end

  always_ff @(posedge clk) begin
    if (out_vld_r && !out_ch.ready) begin
      if (fin_take) begin
        skid_head_r <= fin_head_r;
        skid_deg_r  <= fin_deg_r;
      end
    end else if (skid_vld_r) begin
      out_head_r <= skid_head_r;
      out_deg_r  <= skid_deg_r;
    end else begin
      out_head_r <= fin_head_r;
      out_deg_r  <= fin_deg_r;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.heading    = out_head_r;
  assign out_ch.degenerate = out_deg_r;

  `TCC_ASSERT_IMP(a_skid_behind_out, skid_vld_r, out_vld_r,
                  "skid register holds a transaction while the output is empty")
  `TCC_ASSERT_IMP(a_deg_zero_heading, out_vld_r && out_deg_r, out_head_r == '0,
                  "degenerate result with a nonzero heading")
  `TCC_ASSERT_NXT(a_skid_fill, !skid_vld_r && fin_vld_r && out_vld_r && !out_ch.ready,
                  skid_vld_r && out_vld_r,
                  "stalled result was not caught by the skid register")

endmodule

// ===== test/heading_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// heading_checker
// Watches the input, result and register channels of the compass heading
// block. It keeps its own copy of the registers, works out the heading of
// every accepted input transaction and compares each result transaction with
// the oldest expected heading.
// ----------------------------------------------------------------------------
module heading_checker import tcc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  tcc_in_if    in_ch,
  tcc_out_if   out_ch,
  tcc_cfg_if   cfg_ch,
  output int   fail_count,
  output int   headings_pending
);

  localparam int FRAC = TCC_ANGLE_FRAC;

  typedef struct packed {
    logic [TCC_HEAD_W-1:0] heading;
    logic                  degenerate;
  } heading_res_t;

  heading_res_t expected_headings[$];
  tcc_cfg_t     regs;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic heading_res_t compute_heading(tcc_in_t s, tcc_cfg_t c);
    longint mx, my, mz, ax, ay, az, ex, ey, ez, nx, ny, nz;
    longint pe, pn, bx, by, x, y, z, dx, dy, ang, r;
    longint unsigned ux, uy, mm, sa;
    heading_res_t res;
    mx = longint'(s.mag_x) - longint'(c.offset_x);
    my = longint'(s.mag_y) - longint'(c.offset_y);
    mz = longint'(s.mag_z) - longint'(c.offset_z);
    ax = s.accel_x;
    ay = s.accel_y;
    az = s.accel_z;
    ex = my * az - mz * ay;
    ey = mz * ax - mx * az;
    ez = mx * ay - my * ax;
    res = '0;
    if (ex == 0 && ey == 0 && ez == 0) begin
      res.degenerate = 1'b1;
      return res;
    end
    nx = ay * ez - az * ey;
    ny = az * ex - ax * ez;
    nz = ax * ey - ay * ex;
    pe = ex * longint'(c.ref_x) + ey * longint'(c.ref_y) + ez * longint'(c.ref_z);
    pn = nx * longint'(c.ref_x) + ny * longint'(c.ref_y) + nz * longint'(c.ref_z);
    sa = int_sqrt(longint'(ax * ax + ay * ay + az * az) * 256);
    bx = pe * longint'(sa);
    by = pn * 16;
    if (bx == 0 && by == 0) return res;
    ux = (bx < 0) ? -bx : bx;
    uy = (by < 0) ? -by : by;
    mm = (ux > uy) ? ux : uy;
    while (mm >= (64'd1 << 30)) begin
      ux = ux >> 1; uy = uy >> 1; mm = mm >> 1;
    end
    while (mm < (64'd1 << 29)) begin
      ux = ux << 1; uy = uy << 1; mm = mm << 1;
    end
    x = uy;
    y = ux;
    z = 0;
    for (int i = 0; i < TCC_CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx; y = y - dy; z = z + TCC_ATAN_TAB[i];
      end else begin
        x = x - dx; y = y + dy; z = z - TCC_ATAN_TAB[i];
      end
    end
    if (by >= 0 && bx >= 0) ang = z;
    else if (by < 0 && bx >= 0) ang = (longint'(180) << 16) - z;
    else if (by < 0) ang = (longint'(180) << 16) + z;
    else ang = (longint'(360) << 16) - z;
    r = (ang + (longint'(1) << (15 - FRAC))) >>> (16 - FRAC);
    while (r < 0) r = r + (longint'(360) << FRAC);
    while (r >= (longint'(360) << FRAC)) r = r - (longint'(360) << FRAC);
    res.heading = r[TCC_HEAD_W-1:0];
    return res;
  endfunction

  assign headings_pending = expected_headings.size();

  always @(posedge clk) begin
    tcc_in_t      smp;
    heading_res_t got, want;
    if (!rst_n) begin
      regs <= '{TCC_RST_OFFSET_X, TCC_RST_OFFSET_Y, TCC_RST_OFFSET_Z,
                TCC_RST_REF_X, TCC_RST_REF_Y, TCC_RST_REF_Z};
      fail_count <= 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          TCC_REG_OFFSET_X: regs.offset_x <= cfg_ch.data;
          TCC_REG_OFFSET_Y: regs.offset_y <= cfg_ch.data;
          TCC_REG_OFFSET_Z: regs.offset_z <= cfg_ch.data;
          TCC_REG_REF_X:    regs.ref_x <= cfg_ch.data[TCC_REF_W-1:0];
          TCC_REG_REF_Y:    regs.ref_y <= cfg_ch.data[TCC_REF_W-1:0];
          TCC_REG_REF_Z:    regs.ref_z <= cfg_ch.data[TCC_REF_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        smp = '{in_ch.mag_x, in_ch.mag_y, in_ch.mag_z,
                in_ch.accel_x, in_ch.accel_y, in_ch.accel_z};
        expected_headings.push_back(compute_heading(smp, regs));
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.heading, out_ch.degenerate};
        if (expected_headings.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result transaction: heading %0d degenerate %0b",
                     got.heading, got.degenerate);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_headings.pop_front();
          if (got != want) begin
            if (fail_count < 10)
              $display("mismatch: heading exp %0d got %0d, degenerate exp %0b got %0b",
                       want.heading, got.heading, want.degenerate, got.degenerate);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the compass heading block: directed corner samples, then
// random samples under several register settings, with bursty input traffic
// and a stalling result receiver. The checker does all comparisons.
// ----------------------------------------------------------------------------
module testbench import tcc_pkg::*;;

  localparam logic [TCC_IDX_W-1:0] UNUSED_REG_A = 3'd6;
  localparam logic [TCC_IDX_W-1:0] UNUSED_REG_B = 3'd7;
  localparam int IDLE_LIMIT = 3000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count, headings_pending;
  int   idle_cycles = 0;
  int   burst_left = 0;
  int   rx_cycle = 0;

  tcc_in_if  in_ch();
  tcc_out_if out_ch();
  tcc_cfg_if cfg_ch();

  always #10 clk = ~clk;

  tilt_compensated_compass_heading_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  heading_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .fail_count(fail_count), .headings_pending(headings_pending)
  );

  // The receiver cycles through always-ready, random and heavy-stall modes.
  always @(negedge clk) begin
    rx_cycle <= rx_cycle + 1;
    case ((rx_cycle / 250) % 3)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= 1'($urandom_range(1, 0));
      default: out_ch.ready <= ($urandom_range(3, 0) == 0);
    endcase
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  task automatic write_reg(logic [TCC_IDX_W-1:0] idx, logic [TCC_SENS_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic write_all(logic [15:0] ox, logic [15:0] oy, logic [15:0] oz,
                           logic [15:0] rx, logic [15:0] ry, logic [15:0] rz);
    wait (headings_pending == 0);
    repeat (60) @(posedge clk);
    write_reg(TCC_REG_OFFSET_X, ox);
    write_reg(TCC_REG_OFFSET_Y, oy);
    write_reg(TCC_REG_OFFSET_Z, oz);
    write_reg(TCC_REG_REF_X, rx);
    write_reg(TCC_REG_REF_Y, ry);
    write_reg(TCC_REG_REF_Z, rz);
  endtask

  // Drives one sample; a random gap follows once the current burst is spent.
  task automatic send_sample(logic [15:0] mx, logic [15:0] my, logic [15:0] mz,
                             logic [15:0] ax, logic [15:0] ay, logic [15:0] az);
    @(negedge clk);
    if (burst_left == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(6, 0)) @(negedge clk);
      burst_left = $urandom_range(30, 1);
    end
    burst_left--;
    in_ch.valid   = 1'b1;
    in_ch.mag_x   = mx;
    in_ch.mag_y   = my;
    in_ch.mag_z   = mz;
    in_ch.accel_x = ax;
    in_ch.accel_y = ay;
    in_ch.accel_z = az;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  function automatic logic [15:0] rand_field(int kind);
    case (kind)
      0: return 16'($urandom());
      1: return 16'($urandom_range(400, 0) - 200);
      2: return $urandom_range(1, 0) ? 16'h7fff : 16'h8000;
      default: return 16'($urandom_range(20000, 0) - 10000);
    endcase
  endfunction

  task automatic random_samples(int count, logic [15:0] ox, logic [15:0] oy,
                                logic [15:0] oz);
    int kind, shape;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(3, 0);
      shape = $urandom_range(9, 0);
      if (shape == 0)
        send_sample(rand_field(kind), rand_field(kind), rand_field(kind), 0, 0, 0);
      else if (shape == 1)
        send_sample(ox, oy, oz, rand_field(kind), rand_field(kind), rand_field(kind));
      else if (shape == 2)
        send_sample(rand_field(0), rand_field(0), rand_field(0),
                    0, 0, $urandom_range(1, 0) ? 16'd16384 : -16'sd16384);
      else
        send_sample(rand_field(kind), rand_field(kind), rand_field(kind),
                    rand_field($urandom_range(3, 0)), rand_field($urandom_range(3, 0)),
                    rand_field($urandom_range(3, 0)));
    end
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  initial begin
    in_ch.valid = 1'b0;
    {in_ch.mag_x, in_ch.mag_y, in_ch.mag_z} = '0;
    {in_ch.accel_x, in_ch.accel_y, in_ch.accel_z} = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = TCC_REG_OFFSET_X;
    cfg_ch.data  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed samples under the reset register values.
    send_sample(0, 0, 0, 0, 0, 0);
    send_sample(346, -1133, -525, 100, 200, 16000);
    send_sample(1000, 2000, 3000, 0, 0, 0);
    send_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_sample(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    send_sample(16'h8000, 16'h7fff, 0, 0, 16'h8000, 16'h7fff);
    send_sample(5000, 0, 0, 0, 0, 16384);
    send_sample(0, 5000, 0, 0, 0, 16384);
    send_sample(-5000, 0, 0, 0, 0, 16384);
    send_sample(0, -5000, 0, 0, 0, 16384);
    send_sample(3000, 3000, -2000, 0, 0, -16384);
    send_sample(-1, -1, -1, -1, -1, -1);
    send_sample(1, 1, 1, 1, 1, 1);
    @(negedge clk);
    in_ch.valid = 1'b0;

    // Reference along vertical: both projections vanish.
    write_all(0, 0, 0, 0, 0, 1);
    write_reg(UNUSED_REG_A, 16'hffff);
    write_reg(UNUSED_REG_B, 16'h5555);
    send_sample(1200, -700, 300, 0, 0, 16384);
    send_sample(-9000, 4000, 77, 0, 0, -16000);
    send_sample(0, 0, 0, 0, 0, 1);
    random_samples(190, 0, 0, 0);

    write_all(16'h7fff, 16'h7fff, 16'h7fff, 16'h007f, 16'h007f, 16'h007f);
    random_samples(190, 16'h7fff, 16'h7fff, 16'h7fff);
    write_all(16'h8000, 16'h8000, 16'h8000, 16'hff80, 16'hff80, 16'hff80);
    random_samples(190, 16'h8000, 16'h8000, 16'h8000);
    write_all(346, -1133, -525, 1, 0, 0);
    random_samples(190, 346, -1133, -525);
    for (int p = 0; p < 2; p++) begin
      logic [15:0] ox, oy, oz;
      ox = 16'($urandom());
      oy = 16'($urandom());
      oz = 16'($urandom());
      write_all(ox, oy, oz, 16'($urandom()), 16'($urandom()), 16'($urandom()));
      random_samples(190, ox, oy, oz);
    end

    wait (headings_pending == 0);
    repeat (70) @(posedge clk);
    if (fail_count == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule
